// ----- rtl/psd_pkg.sv -----
// shared types for the per-key stride detector
// no dependencies; imported by the table, the update logic and the top level
package psd_pkg;

    typedef enum logic [1:0]
    {
        ST_UNSEEN = 2'd0,
        ST_OK     = 2'd1,
        ST_BROKEN = 2'd2
    } psd_status_t;

    typedef enum logic
    {
        MODE_SAMPLE = 1'b0,
        MODE_QUERY  = 1'b1
    } psd_mode_t;

    // what one update does to the table and the running count
    typedef struct packed
    {
        logic wr;
        logic cnt_inc;
        logic cnt_dec;
    } psd_upd_ctrl_t;

endpackage

// ----- rtl/psd_table.sv -----
// per-key entry store: one synchronous memory with a registered read port
// and a clearing sweep after reset; uses psd_pkg
module psd_table
    import psd_pkg::*;
#(
    parameter int KEY_BITS   = 12,
    parameter int ENTRY_BITS = 42
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rd_en,
    input  logic [KEY_BITS-1:0]   rd_addr,
    output logic [ENTRY_BITS-1:0] rd_data,
    input  logic                  wr_en,
    input  logic [KEY_BITS-1:0]   wr_addr,
    input  logic [ENTRY_BITS-1:0] wr_data,
    output logic                  clearing
);

    localparam int DEPTH = 1 << KEY_BITS;

    logic [ENTRY_BITS-1:0] mem [DEPTH];
    logic [ENTRY_BITS-1:0] rd_data_reg;
    logic                  clr_active_reg;
    logic                  clr_active_next;
    logic [KEY_BITS-1:0]   clr_addr_reg;
    logic [KEY_BITS-1:0]   clr_addr_next;
    logic                  mem_we;
    logic [KEY_BITS-1:0]   mem_wa;
    logic [ENTRY_BITS-1:0] mem_wd;

    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == {KEY_BITS{1'b1}})
            begin
                clr_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
        end
    end

    // status field zero means unseen, so a zero word clears the entry
    assign mem_we = clr_active_reg || wr_en;
    assign mem_wa = clr_active_reg ? clr_addr_reg : wr_addr;
    assign mem_wd = clr_active_reg ? '0 : wr_data;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clr_active_reg;

endmodule

// ----- rtl/psd_update.sv -----
// next-entry logic for one item: status, last position and stride
// uses psd_pkg
module psd_update
    import psd_pkg::*;
#(
    parameter int POSITION_BITS = 20
)
(
    input  psd_mode_t               mode,
    input  psd_status_t             cur_status,
    input  logic [POSITION_BITS-1:0] cur_last,
    input  logic [POSITION_BITS-1:0] cur_stride,
    input  logic [POSITION_BITS-1:0] pos,
    output psd_status_t             new_status,
    output logic [POSITION_BITS-1:0] new_last,
    output logic [POSITION_BITS-1:0] new_stride,
    output psd_upd_ctrl_t           ctrl
);

    logic [POSITION_BITS-1:0] gap;

    assign gap = pos - cur_last;

    always_comb
    begin
        new_status = cur_status;
        new_last   = cur_last;
        new_stride = cur_stride;
        ctrl       = '0;
        if (mode == MODE_SAMPLE)
        begin
            case (cur_status)
                ST_UNSEEN:
                begin
                    new_status   = ST_OK;
                    new_last     = pos;
                    new_stride   = '0;
                    ctrl.wr      = 1'b1;
                    ctrl.cnt_inc = 1'b1;
                end
                ST_OK:
                begin
                    ctrl.wr = 1'b1;
                    if (cur_stride == '0)
                    begin
                        new_stride = gap;
                        new_last   = pos;
                    end
                    else if (gap == cur_stride)
                    begin
                        new_last = pos;
                    end
                    else
                    begin
                        new_status   = ST_BROKEN;
                        ctrl.cnt_dec = 1'b1;
                    end
                end
                // broken keys never change again
                default:
                begin
                    ctrl = '0;
                end
            endcase
        end
    end

endmodule

// ----- rtl/per_key_stride_detector_top.sv -----
// Per-key stride detector. Each item samples a key into the stream (mode 0) or
// queries a key's entry (mode 1) and yields one result item holding the key's
// present/progression_ok/stride state and the running valid_keys and items_seen
// counts. Items flow at one per cycle unless out_stall holds them: the entry table
// is one synchronous memory read at accept and written back as the item leaves s1,
// and a forwarding register covers an item that hits the key written by the item
// just ahead of it. Each result is registered into the output registers as its
// item leaves s1. After reset the table is swept clear of all 2^KEY_BITS entries
// (4096 at the default), and in_stall stays high until the sweep is done.
// Depends on psd_pkg, psd_table and psd_update.
module per_key_stride_detector_top
    import psd_pkg::*;
#(
    parameter int KEY_BITS      = 12,
    parameter int POSITION_BITS = 20
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     mode,
    input  logic [KEY_BITS-1:0]      key,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     present,
    output logic                     progression_ok,
    output logic [POSITION_BITS-1:0] stride,
    output logic [KEY_BITS:0]        valid_keys,
    output logic [POSITION_BITS-1:0] items_seen
);

    localparam int ENTRY_BITS = 2 + 2 * POSITION_BITS;

    logic                     clearing;
    logic                     in_accept;
    logic                     advance;
    logic [ENTRY_BITS-1:0]    rd_data;
    logic [ENTRY_BITS-1:0]    cur_entry;
    logic [ENTRY_BITS-1:0]    new_entry;

    logic                     s1_valid_reg;
    logic                     s1_valid_next;
    psd_mode_t                s1_mode_reg;
    logic [KEY_BITS-1:0]      s1_key_reg;
    logic                     fwd_hit_reg;
    logic [ENTRY_BITS-1:0]    fwd_entry_reg;

    logic [POSITION_BITS-1:0] pos_cnt_reg;
    logic [POSITION_BITS-1:0] pos_cnt_next;
    logic [KEY_BITS:0]        key_cnt_reg;
    logic [KEY_BITS:0]        key_cnt_next;
    logic [POSITION_BITS-1:0] pos_sat;

    psd_status_t              cur_status;
    psd_status_t              new_status;
    logic [POSITION_BITS-1:0] new_last;
    logic [POSITION_BITS-1:0] new_stride;
    psd_upd_ctrl_t            upd_ctrl;
    logic                     do_write;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic                     present_reg;
    logic                     ok_reg;
    logic [POSITION_BITS-1:0] stride_reg;
    logic [KEY_BITS:0]        valid_keys_reg;
    logic [POSITION_BITS-1:0] items_seen_reg;

    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = clearing || (s1_valid_reg && !advance);
    assign in_accept = in_valid && !in_stall;

    psd_table #(
        .KEY_BITS   (KEY_BITS),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (in_accept),
        .rd_addr  (key),
        .rd_data  (rd_data),
        .wr_en    (do_write),
        .wr_addr  (s1_key_reg),
        .wr_data  (new_entry),
        .clearing (clearing)
    );

    // the previous item's write lands at the same edge this read is taken
    assign cur_entry  = fwd_hit_reg ? fwd_entry_reg : rd_data;
    assign cur_status = psd_status_t'(cur_entry[ENTRY_BITS-1 -: 2]);

    assign pos_sat = (pos_cnt_reg == {POSITION_BITS{1'b1}}) ? pos_cnt_reg
                                                             : pos_cnt_reg + 1'b1;

    psd_update #(
        .POSITION_BITS (POSITION_BITS)
    ) u_update (
        .mode       (s1_mode_reg),
        .cur_status (cur_status),
        .cur_last   (cur_entry[2*POSITION_BITS-1 -: POSITION_BITS]),
        .cur_stride (cur_entry[POSITION_BITS-1:0]),
        .pos        (pos_sat),
        .new_status (new_status),
        .new_last   (new_last),
        .new_stride (new_stride),
        .ctrl       (upd_ctrl)
    );

    assign new_entry = {new_status, new_last, new_stride};
    assign do_write  = s1_valid_reg && advance && upd_ctrl.wr;

    always_comb
    begin
        pos_cnt_next   = pos_cnt_reg;
        key_cnt_next   = key_cnt_reg;
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (s1_valid_reg && advance)
        begin
            s1_valid_next  = 1'b0;
            out_valid_next = 1'b1;
            if (s1_mode_reg == MODE_SAMPLE)
            begin
                pos_cnt_next = pos_sat;
            end
            if (upd_ctrl.cnt_inc)
            begin
                key_cnt_next = key_cnt_reg + 1'b1;
            end
            else if (upd_ctrl.cnt_dec)
            begin
                key_cnt_next = key_cnt_reg - 1'b1;
            end
        end
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_cnt_reg   <= '0;
            key_cnt_reg   <= '0;
            fwd_hit_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            pos_cnt_reg   <= pos_cnt_next;
            key_cnt_reg   <= key_cnt_next;
            if (in_accept)
            begin
                fwd_hit_reg <= do_write && (s1_key_reg == key);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_mode_reg   <= psd_mode_t'(mode);
            s1_key_reg    <= key;
            fwd_entry_reg <= new_entry;
        end
        if (s1_valid_reg && advance)
        begin
            present_reg    <= (new_status != ST_UNSEEN);
            ok_reg         <= (new_status == ST_OK);
            stride_reg     <= (new_status == ST_OK) ? new_stride : '0;
            valid_keys_reg <= key_cnt_next;
            items_seen_reg <= pos_cnt_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign present        = present_reg;
    assign progression_ok = ok_reg;
    assign stride         = stride_reg;
    assign valid_keys     = valid_keys_reg;
    assign items_seen     = items_seen_reg;

endmodule
